/* hdl/sht_pkg.sv */
// shared types and constants for the site heterozygosity / theta block
// genotype and result beat structs, allele character codes, genotype classes
// no dependencies
`timescale 1ns / 1ps

package sht_pkg;

  // allele character codes
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_T       = 8'h54;
  localparam logic [7:0] CH_G       = 8'h47;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_N_UPPER = 8'h4E;
  localparam logic [7:0] CH_N_LOWER = 8'h6E;

  // genotype classes
  localparam logic [1:0] CLASS_MISSING = 2'd0;
  localparam logic [1:0] CLASS_HOM     = 2'd1;
  localparam logic [1:0] CLASS_HET     = 2'd2;

  localparam int CFG_WIDTH = 7;

  typedef struct packed {
    logic [7:0] allele_first;
    logic [7:0] allele_second;
    logic       last_of_contig;
  } genotype_t;

  typedef struct packed {
    logic [5:0]  individual;
    logic [1:0]  genotype_class;
    logic [15:0] contig_hom_count;
    logic [15:0] contig_het_count;
    logic        bad_character;
    logic [2:0]  site_diversity;
    logic        contig_end;
    logic [15:0] sites_kept;
    logic [15:0] biallelic_sites;
    logic [15:0] triallelic_sites;
    logic [15:0] quadallelic_sites;
    logic [15:0] theta_mean;
  } result_t;

endpackage

/* hdl/sht_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/site_heterozygosity_theta.sv */
// path: a genotype beat is captured in stage b, and its result beat is registered when
//   stage b advances; a contig's last beat waits in stage b for the mean-theta divider
// throughput: one genotype beat per cycle unless the output stalls, set by the
//   count ram read-modify-write; each contig end stalls input (divider load, 33 steps)
// reset: synchronous, active high; clears site/contig state and sets individuals to 1.
//   the count ram is not cleared: the first site of each contig starts counts from zero
`timescale 1ns / 1ps

module site_heterozygosity_theta
  import sht_pkg::*;
#(
  parameter int MAX_INDIVIDUALS     = 64,
  parameter int COUNT_WIDTH         = 16,
  parameter int THETA_FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  input  logic                 genotype_valid,
  output logic                 genotype_ready,
  input  genotype_t            genotype,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result
);

  // widths
  localparam int IDX_W   = (MAX_INDIVIDUALS > 1) ? $clog2(MAX_INDIVIDUALS) : 1;
  localparam int ROM_W   = $clog2(MAX_INDIVIDUALS + 1);     // holds 0..MAX_INDIVIDUALS
  localparam int CMP_W   = (ROM_W > CFG_WIDTH) ? ROM_W : CFG_WIDTH;
  localparam int EXT_W   = COUNT_WIDTH + 16;
  localparam int IEXT_W  = IDX_W + 6;
  localparam int DIV_BITS = 33;                               // dividend width
  localparam int STEP_W  = $clog2(DIV_BITS);
  localparam logic [15:0] THETA_CAP =
    (THETA_FRACTION_BITS >= 16) ? 16'hFFFF : 16'((1 << THETA_FRACTION_BITS) - 1);

  // divider sequencer
  typedef enum logic [3:0] {
    DIV_IDLE = 4'b0001,
    DIV_LOAD = 4'b0010,
    DIV_RUN  = 4'b0100,
    DIV_DONE = 4'b1000
  } div_state_t;

  // ---------------------------------------------------------------------------
  // 1/a_n table, built at elaboration
  // entry n: round(2^(frac+32) / sum_{i=1..m} floor(2^32/i)), m = max(1, 2n-1)
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    int          k;
    r = '0;
    q = num;
    for (k = 0; k < 64; k++) begin
      r = {r[63:0], q[63]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [31:0] inv_harmonic(input int n);
    logic [63:0] a;
    logic [63:0] m;
    logic [63:0] i;
    logic [63:0] num;
    logic [63:0] q;
    a = '0;
    m = (n == 0) ? 64'd1 : 64'(2 * n - 1);
    for (i = 64'd1; i <= m; i++) begin
      a = a + udiv64(64'd1 << 32, i);
    end
    num = (64'd1 << (THETA_FRACTION_BITS + 32)) + (a >> 1);
    q   = udiv64(num, a);
    return q[31:0];
  endfunction

  logic [31:0] rom_table [MAX_INDIVIDUALS+1];

  for (genvar g = 0; g <= MAX_INDIVIDUALS; g++) begin : g_rom
    localparam logic [31:0] ENTRY = inv_harmonic(g);
    assign rom_table[g] = ENTRY;
  end

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // count values go out as their low 16 bits
  function automatic logic [15:0] to_field(input logic [COUNT_WIDTH-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // site and contig state
  // ---------------------------------------------------------------------------
  logic [CFG_WIDTH-1:0]   individuals;
  logic [IDX_W-1:0]       idx_count;
  logic [3:0]             bases_seen;
  logic [ROM_W-1:0]       called;
  logic                   first_site;
  logic [COUNT_WIDTH-1:0] kept_count;
  logic [COUNT_WIDTH-1:0] bi_count;
  logic [COUNT_WIDTH-1:0] tri_count;
  logic [COUNT_WIDTH-1:0] quad_count;
  logic [31:0]            theta_acc;

  // stage b: item waiting on ram read data, and the contig snapshot
  logic                   b_valid;
  logic [IDX_W-1:0]       b_idx;
  logic [1:0]             b_cls;
  logic                   b_bad;
  logic                   b_first;
  logic [2:0]             b_div;
  logic                   b_end;
  logic [COUNT_WIDTH-1:0] b_kept;
  logic [COUNT_WIDTH-1:0] b_bi;
  logic [COUNT_WIDTH-1:0] b_tri;
  logic [COUNT_WIDTH-1:0] b_quad;
  logic [31:0]            b_acc;
  logic                   b_fwd;
  logic [2*COUNT_WIDTH-1:0] b_fwd_data;

  // divider
  div_state_t             div_state;
  div_state_t             div_state_next;
  logic [DIV_BITS-1:0]    div_q;
  logic [COUNT_WIDTH-1:0] div_r;
  logic [STEP_W-1:0]      div_step;

  // ---------------------------------------------------------------------------
  // genotype decode, combinational on the incoming beat
  // ---------------------------------------------------------------------------
  logic       accept;
  logic [3:0] bits_first;
  logic [3:0] bits_second;
  logic       bad_first;
  logic       bad_second;
  logic       bad;
  logic       first_missing;
  logic [1:0] cls;

  assign accept = genotype_valid && genotype_ready;

  always_comb begin
    bits_first = 4'b0000;
    bad_first  = 1'b0;
    case (genotype.allele_first)
      CH_A:                   bits_first = 4'b0001;
      CH_T:                   bits_first = 4'b0010;
      CH_G:                   bits_first = 4'b0100;
      CH_C:                   bits_first = 4'b1000;
      CH_N_UPPER, CH_N_LOWER: bits_first = 4'b0000;
      default:                bad_first  = 1'b1;
    endcase
    bits_second = 4'b0000;
    bad_second  = 1'b0;
    case (genotype.allele_second)
      CH_A:                   bits_second = 4'b0001;
      CH_T:                   bits_second = 4'b0010;
      CH_G:                   bits_second = 4'b0100;
      CH_C:                   bits_second = 4'b1000;
      CH_N_UPPER, CH_N_LOWER: bits_second = 4'b0000;
      default:                bad_second  = 1'b1;
    endcase
  end

  assign bad           = bad_first || bad_second;
  assign first_missing = (genotype.allele_first == CH_N_UPPER) ||
                         (genotype.allele_first == CH_N_LOWER);

  always_comb begin
    if (bad || first_missing) begin
      cls = CLASS_MISSING;
    end else if (genotype.allele_first == genotype.allele_second) begin
      cls = CLASS_HOM;
    end else begin
      cls = CLASS_HET;
    end
  end

  // ---------------------------------------------------------------------------
  // site end bookkeeping
  // ---------------------------------------------------------------------------
  logic [3:0]             seen_next;
  logic [ROM_W-1:0]       called_next;
  logic [ROM_W-1:0]       rom_index;
  logic [CMP_W-1:0]       reg_ext;
  logic [CMP_W-1:0]       eff;
  logic                   last_item;
  logic                   contig_end_in;
  logic [2:0]             diversity;
  logic [COUNT_WIDTH-1:0] kept_next;
  logic [COUNT_WIDTH-1:0] bi_next;
  logic [COUNT_WIDTH-1:0] tri_next;
  logic [COUNT_WIDTH-1:0] quad_next;
  logic [32:0]            theta_sum;
  logic [31:0]            acc_next;

  assign seen_next   = bases_seen | (bad ? 4'b0000 : (bits_first | bits_second));
  assign called_next = called + ROM_W'(!bad && !first_missing);
  assign rom_index   = (called_next > ROM_W'(MAX_INDIVIDUALS)) ?
                       ROM_W'(MAX_INDIVIDUALS) : called_next;

  // effective individuals per site, clamped to 1..MAX_INDIVIDUALS
  assign reg_ext = CMP_W'(individuals);
  always_comb begin
    if (reg_ext == '0) begin
      eff = CMP_W'(1);
    end else if (reg_ext > CMP_W'(MAX_INDIVIDUALS)) begin
      eff = CMP_W'(MAX_INDIVIDUALS);
    end else begin
      eff = reg_ext;
    end
  end

  assign last_item     = (CMP_W'(idx_count) + CMP_W'(1)) >= eff;
  assign contig_end_in = last_item && genotype.last_of_contig;

  assign diversity = 3'(seen_next[0]) + 3'(seen_next[1]) + 3'(seen_next[2]) +
                     3'(seen_next[3]);

  // polymorphic sites add 1/a_n, saturating at the accumulator width
  assign theta_sum = {1'b0, theta_acc} + {1'b0, rom_table[rom_index]};

  always_comb begin
    kept_next = kept_count;
    bi_next   = bi_count;
    tri_next  = tri_count;
    quad_next = quad_count;
    acc_next  = theta_acc;
    if (diversity != 3'd0) begin
      kept_next = sat_inc(kept_count);
    end
    case (diversity)
      3'd2:    bi_next   = sat_inc(bi_count);
      3'd3:    tri_next  = sat_inc(tri_count);
      3'd4:    quad_next = sat_inc(quad_count);
      default: ;
    endcase
    if (diversity > 3'd1) begin
      acc_next = theta_sum[32] ? 32'hFFFF_FFFF : theta_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      individuals <= CFG_WIDTH'(1);
    end else if (cfg_write) begin
      individuals <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_count  <= '0;
      bases_seen <= '0;
      called     <= '0;
      first_site <= 1'b1;
      kept_count <= '0;
      bi_count   <= '0;
      tri_count  <= '0;
      quad_count <= '0;
      theta_acc  <= '0;
    end else if (accept) begin
      if (!last_item) begin
        idx_count  <= idx_count + 1'b1;
        bases_seen <= seen_next;
        called     <= called_next;
      end else begin
        idx_count  <= '0;
        bases_seen <= '0;
        called     <= '0;
        if (genotype.last_of_contig) begin
          // summary goes to stage b, contig starts over
          first_site <= 1'b1;
          kept_count <= '0;
          bi_count   <= '0;
          tri_count  <= '0;
          quad_count <= '0;
          theta_acc  <= '0;
        end else begin
          first_site <= 1'b0;
          kept_count <= kept_next;
          bi_count   <= bi_next;
          tri_count  <= tri_next;
          quad_count <= quad_next;
          theta_acc  <= acc_next;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // per-individual counts: ram read at accept, modify and write back in stage b
  // ---------------------------------------------------------------------------
  logic                     b_advance;
  logic [2*COUNT_WIDTH-1:0] ram_q;
  logic [2*COUNT_WIDTH-1:0] count_base;
  logic [COUNT_WIDTH-1:0]   hom_new;
  logic [COUNT_WIDTH-1:0]   het_new;
  logic [2*COUNT_WIDTH-1:0] count_wdata;

  assign b_advance = b_valid && (!b_end || (div_state == DIV_DONE)) &&
                     (!result_valid || result_ready);
  assign genotype_ready = !b_valid || b_advance;

  sht_ram #(
    .WIDTH (2 * COUNT_WIDTH),
    .DEPTH (MAX_INDIVIDUALS)
  ) u_count_ram (
    .clk   (clk),
    .we    (b_advance),
    .waddr (b_idx),
    .wdata (count_wdata),
    .re    (accept),
    .raddr (idx_count),
    .rdata (ram_q)
  );

  // first site of a contig starts from zero; a write landing on the entry
  // being read in the same cycle is forwarded (ram returns old data)
  always_comb begin
    if (b_first) begin
      count_base = '0;
    end else if (b_fwd) begin
      count_base = b_fwd_data;
    end else begin
      count_base = ram_q;
    end
  end

  assign hom_new = (b_cls == CLASS_HOM) ? sat_inc(count_base[2*COUNT_WIDTH-1:COUNT_WIDTH]) :
                   count_base[2*COUNT_WIDTH-1:COUNT_WIDTH];
  assign het_new = (b_cls == CLASS_HET) ? sat_inc(count_base[COUNT_WIDTH-1:0]) :
                   count_base[COUNT_WIDTH-1:0];
  assign count_wdata = {hom_new, het_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_advance) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_idx      <= idx_count;
      b_cls      <= cls;
      b_bad      <= bad;
      b_first    <= first_site;
      b_div      <= last_item ? diversity : 3'd0;
      b_end      <= contig_end_in;
      b_kept     <= kept_next;
      b_bi       <= bi_next;
      b_tri      <= tri_next;
      b_quad     <= quad_next;
      b_acc      <= acc_next;
      b_fwd      <= b_advance && (b_idx == idx_count);
      b_fwd_data <= count_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // mean theta: round(acc / kept) by restoring division, one bit per cycle
  // ---------------------------------------------------------------------------
  logic [COUNT_WIDTH:0] rem_shift;
  logic [COUNT_WIDTH:0] divisor_ext;
  logic                 rem_ge;
  logic [COUNT_WIDTH:0] rem_sub;
  logic [15:0]          theta_mean;

  assign rem_shift   = {div_r, div_q[DIV_BITS-1]};
  assign divisor_ext = {1'b0, b_kept};
  assign rem_ge      = rem_shift >= divisor_ext;
  assign rem_sub     = rem_ge ? (rem_shift - divisor_ext) : rem_shift;

  always_comb begin
    div_state_next = div_state;
    case (div_state)
      DIV_IDLE: begin
        if (accept && contig_end_in) begin
          div_state_next = DIV_LOAD;
        end
      end
      DIV_LOAD: div_state_next = DIV_RUN;
      DIV_RUN: begin
        if (div_step == STEP_W'(DIV_BITS - 1)) begin
          div_state_next = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (accept && contig_end_in) begin
          div_state_next = DIV_LOAD;
        end else if (b_advance) begin
          div_state_next = DIV_IDLE;
        end
      end
      default: div_state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_state <= DIV_IDLE;
    end else begin
      div_state <= div_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (div_state == DIV_LOAD) begin
      // add half the divisor for round half up
      div_q    <= {1'b0, b_acc} + DIV_BITS'(b_kept >> 1);
      div_r    <= '0;
      div_step <= '0;
    end else if (div_state == DIV_RUN) begin
      div_q    <= {div_q[DIV_BITS-2:0], rem_ge};
      div_r    <= rem_sub[COUNT_WIDTH-1:0];
      div_step <= div_step + 1'b1;
    end
  end

  // no kept site means theta 0; otherwise saturate to the output format
  always_comb begin
    if (b_kept == '0) begin
      theta_mean = 16'd0;
    end else if (div_q > DIV_BITS'(THETA_CAP)) begin
      theta_mean = THETA_CAP;
    end else begin
      theta_mean = div_q[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [IEXT_W-1:0] idx_ext;

  assign idx_ext = IEXT_W'(b_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_advance) begin
      result.individual        <= idx_ext[5:0];
      result.genotype_class    <= b_cls;
      result.contig_hom_count  <= to_field(hom_new);
      result.contig_het_count  <= to_field(het_new);
      result.bad_character     <= b_bad;
      result.site_diversity    <= b_div;
      result.contig_end        <= b_end;
      result.sites_kept        <= b_end ? to_field(b_kept) : 16'd0;
      result.biallelic_sites   <= b_end ? to_field(b_bi) : 16'd0;
      result.triallelic_sites  <= b_end ? to_field(b_tri) : 16'd0;
      result.quadallelic_sites <= b_end ? to_field(b_quad) : 16'd0;
      result.theta_mean        <= b_end ? theta_mean : 16'd0;
    end
  end

endmodule

/* hdl/sht_checker.sv */
// port-level checks for site_heterozygosity_theta, attached by bind
// depends on sht_pkg
`timescale 1ns / 1ps

module sht_checker
  import sht_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_ready,
  input result_t   result
);

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // a bad character is always classed missing
  a_bad_is_missing: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_character |-> result.genotype_class == CLASS_MISSING)
    else $error("bad character not classed missing");

  // summary fields stay zero away from a contig end
  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.contig_end |->
      result.sites_kept == 16'd0 && result.biallelic_sites == 16'd0 &&
      result.triallelic_sites == 16'd0 && result.quadallelic_sites == 16'd0 &&
      result.theta_mean == 16'd0)
    else $error("summary field set outside contig end");

  // a contig with no kept site reports no polymorphic site and zero theta
  a_empty_contig: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.contig_end && result.sites_kept == 16'd0 |->
      result.theta_mean == 16'd0 && result.biallelic_sites == 16'd0)
    else $error("empty contig reports theta or sites");

endmodule

bind site_heterozygosity_theta sht_checker u_sht_checker (.*);

/* tb/site_heterozygosity_theta_tb.sv */
// self-checking testbench for site_heterozygosity_theta: genotype beats in, result beats out
// holds its own model of the per-site classifier and contig theta summary in a scoreboard class
// depends on sht_pkg (beat structs, allele codes, genotype classes) and the block itself
`timescale 1ns / 1ps

module site_heterozygosity_theta_tb;
  import sht_pkg::*;

  // sizes of the block as built here
  localparam int              SLOTS         = 64;
  localparam longint unsigned COUNT_CAP     = 64'd65535;
  localparam longint unsigned THETA_SUM_CAP = 64'hFFFF_FFFF;
  localparam longint unsigned MEAN_CAP      = 64'd65535;
  localparam int              FRACTION_BITS = 16;

  // run control
  localparam int RANDOM_ITEMS  = 1450;
  localparam int IDLE_SETTLE   = 45;      // settle margin, longer than the contig end divider
  localparam int DRAIN_LIMIT   = 20000;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 250;

  // a byte that is no allele code at all
  localparam logic [7:0] CH_BAD_X = 8'h78;

  // scoreboard: predicts one result beat per genotype beat and matches them in order
  class heterozygosity_scoreboard;
    logic [6:0]      individuals_reg;
    logic [3:0]      bases_seen;
    int unsigned     slot;
    int unsigned     called_count;
    longint unsigned hom_mem [SLOTS];
    longint unsigned het_mem [SLOTS];
    bit              fresh_contig;
    longint unsigned kept_sites;
    longint unsigned allele_sites [3];   // bi, tri, quad
    longint unsigned theta_sum;
    longint unsigned inv_harmonic [SLOTS+1];
    result_t         awaited_results [$];
    int unsigned     mismatches;

    function new();
      int unsigned     n;
      int unsigned     m;
      longint unsigned a;
      mismatches = 0;
      // 1/a_n table in Q1.16, a_n over 2n-1 terms, n = 0 treated as one term
      for (n = 0; n <= SLOTS; n++) begin
        m = (n == 0) ? 1 : 2 * n - 1;
        a = 0;
        for (int unsigned i = 1; i <= m; i++) begin
          a += (64'd1 << 32) / i;
        end
        inv_harmonic[n] = ((64'd1 << (FRACTION_BITS + 32)) + a / 2) / a;
      end
      individuals_reg = 7'd1;
      bases_seen      = '0;
      slot            = 0;
      called_count    = 0;
      for (int i = 0; i < SLOTS; i++) begin
        hom_mem[i] = 0;
        het_mem[i] = 0;
      end
      clear_contig();
    endfunction

    function void clear_contig();
      fresh_contig = 1'b1;
      kept_sites   = 0;
      for (int i = 0; i < 3; i++) allele_sites[i] = 0;
      theta_sum    = 0;
    endfunction

    function void write_individuals(logic [6:0] value);
      individuals_reg = value;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function longint unsigned sat_inc(longint unsigned v);
      return (v >= COUNT_CAP) ? COUNT_CAP : v + 1;
    endfunction

    function logic [3:0] base_mask(input logic [7:0] c, inout bit bad);
      case (c)
        CH_A:       return 4'b0001;
        CH_T:       return 4'b0010;
        CH_G:       return 4'b0100;
        CH_C:       return 4'b1000;
        CH_N_UPPER: return 4'b0000;
        CH_N_LOWER: return 4'b0000;
        default: begin
          bad = 1'b1;
          return 4'b0000;
        end
      endcase
    endfunction

    // one accepted genotype beat: update the model and queue the result it causes
    function void account_genotype(genotype_t g);
      int unsigned     eff;
      int unsigned     idx;
      int unsigned     diversity;
      int unsigned     n;
      bit              bad;
      bit              first_missing;
      logic [3:0]      mask;
      logic [1:0]      cls;
      longint unsigned hom;
      longint unsigned het;
      longint unsigned mean;
      result_t         r;

      eff = individuals_reg;
      if (eff < 1) eff = 1;
      if (eff > SLOTS) eff = SLOTS;
      idx = (slot >= SLOTS) ? 0 : slot;

      bad  = 1'b0;
      mask = base_mask(g.allele_first, bad);
      mask = mask | base_mask(g.allele_second, bad);
      first_missing = (g.allele_first == CH_N_UPPER) || (g.allele_first == CH_N_LOWER);

      if (bad || first_missing) cls = CLASS_MISSING;
      else if (g.allele_first == g.allele_second) cls = CLASS_HOM;
      else cls = CLASS_HET;

      if (!bad) begin
        bases_seen = bases_seen | mask;
        if (!first_missing) called_count++;
      end

      hom = fresh_contig ? 0 : hom_mem[idx];
      het = fresh_contig ? 0 : het_mem[idx];
      if (cls == CLASS_HOM) hom = sat_inc(hom);
      if (cls == CLASS_HET) het = sat_inc(het);
      hom_mem[idx] = hom;
      het_mem[idx] = het;

      r = '0;
      r.individual       = idx[5:0];
      r.genotype_class   = cls;
      r.contig_hom_count = hom[15:0];
      r.contig_het_count = het[15:0];
      r.bad_character    = bad;

      if (idx + 1 < eff) begin
        slot = idx + 1;
        awaited_results.push_back(r);
        return;
      end

      // site close
      diversity = $countones(bases_seen);
      r.site_diversity = diversity[2:0];
      if (diversity > 0) begin
        kept_sites = sat_inc(kept_sites);
        if (diversity >= 2) begin
          allele_sites[diversity-2] = sat_inc(allele_sites[diversity-2]);
          n = (called_count > SLOTS) ? SLOTS : called_count;
          theta_sum += inv_harmonic[n];
          if (theta_sum > THETA_SUM_CAP) theta_sum = THETA_SUM_CAP;
        end
      end
      slot         = 0;
      bases_seen   = '0;
      called_count = 0;
      fresh_contig = 1'b0;

      if (g.last_of_contig) begin
        mean = 0;
        if (kept_sites > 0) mean = (theta_sum + kept_sites / 2) / kept_sites;
        if (mean > MEAN_CAP) mean = MEAN_CAP;
        r.contig_end        = 1'b1;
        r.sites_kept        = kept_sites[15:0];
        r.biallelic_sites   = allele_sites[0][15:0];
        r.triallelic_sites  = allele_sites[1][15:0];
        r.quadallelic_sites = allele_sites[2][15:0];
        r.theta_mean        = mean[15:0];
        clear_contig();
      end
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    // one accepted result beat against the oldest expectation
    function void match_result(result_t act);
      result_t exp_r;
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, act);
        return;
      end
      exp_r = awaited_results.pop_front();
      compare_field("individual",        16'(exp_r.individual),       16'(act.individual));
      compare_field("genotype_class",    16'(exp_r.genotype_class),   16'(act.genotype_class));
      compare_field("contig_hom_count",  exp_r.contig_hom_count,      act.contig_hom_count);
      compare_field("contig_het_count",  exp_r.contig_het_count,      act.contig_het_count);
      compare_field("bad_character",     16'(exp_r.bad_character),    16'(act.bad_character));
      compare_field("site_diversity",    16'(exp_r.site_diversity),   16'(act.site_diversity));
      compare_field("contig_end",        16'(exp_r.contig_end),       16'(act.contig_end));
      compare_field("sites_kept",        exp_r.sites_kept,            act.sites_kept);
      compare_field("biallelic_sites",   exp_r.biallelic_sites,       act.biallelic_sites);
      compare_field("triallelic_sites",  exp_r.triallelic_sites,      act.triallelic_sites);
      compare_field("quadallelic_sites", exp_r.quadallelic_sites,     act.quadallelic_sites);
      compare_field("theta_mean",        exp_r.theta_mean,            act.theta_mean);
    endfunction

    function void count_leftovers();
      if (awaited_results.size() != 0) begin
        mismatches += awaited_results.size();
        $display("%0t: result beats missing, expected %0d more, actual 0",
                 $time, awaited_results.size());
      end
    endfunction
  endclass

  // clock, reset and block ports; every input known from time zero
  logic                 clk            = 1'b0;
  logic                 rst            = 1'b1;
  logic                 cfg_write      = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_data       = '0;
  logic                 genotype_valid = 1'b0;
  logic                 genotype_ready;
  genotype_t            genotype       = '0;
  logic                 result_valid;
  logic                 result_ready   = 1'b0;
  result_t              result;

  heterozygosity_scoreboard sb;

  // stimulus bookkeeping
  int unsigned current_eff   = 1;     // items per site as the block sees it
  bit          sender_gaps   = 1'b1;
  int unsigned burst_left    = 1;
  bit          hold_request  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned ready_mode    = 0;
  int unsigned mode_left     = 0;
  int unsigned cycle_count   = 0;

  // register settings for the random phases; the extremes and clamped values come early
  logic [6:0] cfg_plan [0:15] = '{7'd3, 7'd127, 7'd1, 7'd5, 7'd0, 7'd8, 7'd64, 7'd2,
                                  7'd65, 7'd6, 7'd4, 7'd12, 7'd7, 7'd2, 7'd3, 7'd9};

  site_heterozygosity_theta DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .genotype_valid (genotype_valid),
    .genotype_ready (genotype_ready),
    .genotype       (genotype),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // beat monitor: both handshakes sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (genotype_valid && genotype_ready) sb.account_genotype(genotype);
      if (result_valid && result_ready) sb.match_result(result);
    end
  end

  // receiver: switches between always-ready, light and heavy stalling,
  // plus a long hold-off on request so the block backs up into its input
  always @(negedge clk) begin
    logic rdy;
    if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
      rdy          = 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 150);
      end
      mode_left--;
      case (ready_mode)
        0:       rdy = 1'b1;
        1:       rdy = ($urandom_range(0, 3) != 0);
        default: rdy = ($urandom_range(0, 2) == 0);
      endcase
    end
    result_ready <= rdy;
  end

  function automatic genotype_t make_genotype(logic [7:0] first, logic [7:0] second,
                                              logic ends_contig);
    genotype_t g;
    g.allele_first   = first;
    g.allele_second  = second;
    g.last_of_contig = ends_contig;
    return g;
  endfunction

  // mostly bases from the site's pool, some missing calls, a few arbitrary bytes
  function automatic logic [7:0] pick_allele(logic [3:0] pool);
    int unsigned roll;
    int unsigned k;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 8'($urandom_range(0, 255));
    if (roll < 18 || pool == 4'b0000) return ($urandom_range(0, 1) != 0) ? CH_N_UPPER : CH_N_LOWER;
    k = $urandom_range(0, 3);
    while (!pool[k]) k = $urandom_range(0, 3);
    case (k)
      0:       return CH_A;
      1:       return CH_T;
      2:       return CH_G;
      default: return CH_C;
    endcase
  endfunction

  // offer one beat and hold it until taken, then maybe open a gap
  task automatic send_genotype(genotype_t g);
    int unsigned gap;
    @(negedge clk);
    genotype_valid <= 1'b1;
    genotype       <= g;
    do @(posedge clk); while (!genotype_ready);
    // no gaps while the receiver is held off: keep pushing into the block
    if (sender_gaps && hold_left == 0) begin
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(1, 6);
        @(negedge clk);
        genotype_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    genotype_valid <= 1'b0;
  endtask

  // every beat causes a result, so an empty queue plus the divider time means idle
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_individuals(logic [6:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.write_individuals(value);
    current_eff = (value == 0) ? 1 : (value > SLOTS) ? SLOTS : value;
  endtask

  // one site: a pool of 0..4 bases shapes the diversity; half the second alleles copy the first
  task automatic send_site(bit ends_contig);
    genotype_t  g;
    logic [3:0] pool;
    case ($urandom_range(0, 5))
      0:       pool = 4'b0000;
      1:       pool = 4'b0001 << $urandom_range(0, 3);
      default: pool = 4'($urandom_range(0, 15));
    endcase
    for (int unsigned i = 0; i < current_eff; i++) begin
      g.allele_first  = pick_allele(pool);
      g.allele_second = ($urandom_range(0, 1) != 0) ? g.allele_first : pick_allele(pool);
      // only the site's last beat carries a meaningful contig flag
      g.last_of_contig = (i == current_eff - 1) ? ends_contig : 1'($urandom_range(0, 1));
      send_genotype(g);
    end
  endtask

  task automatic run_contig(int unsigned sites);
    for (int unsigned s = 0; s < sites; s++) send_site(s == sites - 1);
  endtask

  initial begin
    int unsigned total;
    int unsigned plan_idx;
    int unsigned budget;
    int unsigned phase_items;
    int unsigned sites;
    int unsigned drain;
    logic [6:0]  value;

    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, one individual per site (reset value of the register)
    sender_gaps = 1'b0;
    send_genotype(make_genotype(CH_A, CH_A, 1'b0));              // homozygous
    send_genotype(make_genotype(CH_A, CH_T, 1'b0));              // heterozygous, biallelic
    send_genotype(make_genotype(CH_N_UPPER, CH_A, 1'b0));        // missing, base still seen
    send_genotype(make_genotype(CH_N_LOWER, CH_G, 1'b0));
    send_genotype(make_genotype(CH_A, CH_N_UPPER, 1'b0));        // called first, N second
    send_genotype(make_genotype(CH_N_UPPER, CH_N_LOWER, 1'b0));  // nothing called, not kept
    send_genotype(make_genotype(CH_BAD_X, CH_A, 1'b0));          // bad first byte
    send_genotype(make_genotype(CH_C, 8'hFF, 1'b0));             // bad second byte
    send_genotype(make_genotype(8'h00, 8'h00, 1'b0));
    send_genotype(make_genotype(CH_G, CH_C, 1'b1));              // contig end
    send_genotype(make_genotype(CH_N_UPPER, CH_N_UPPER, 1'b1));  // contig with no kept site
    send_genotype(make_genotype(CH_T, CH_T, 1'b1));
    send_genotype(make_genotype(CH_C, CH_G, 1'b1));              // mean theta saturates
    stop_sending();
    wait_idle();

    // directed, two individuals per site
    write_individuals(7'd2);
    send_genotype(make_genotype(CH_N_UPPER, CH_A, 1'b0));        // polymorphic with no called
    send_genotype(make_genotype(CH_N_LOWER, CH_T, 1'b1));        //   first allele
    send_genotype(make_genotype(CH_G, CH_A, 1'b0));              // all four bases
    send_genotype(make_genotype(CH_C, CH_T, 1'b0));
    send_genotype(make_genotype(CH_G, CH_G, 1'b1));              // three bases
    send_genotype(make_genotype(CH_T, CH_C, 1'b0));
    send_genotype(make_genotype(CH_A, CH_A, 1'b1));
    send_genotype(make_genotype(CH_N_LOWER, CH_N_LOWER, 1'b1));
    stop_sending();
    wait_idle();

    // random phases, each a whole number of contigs under one register setting
    total    = 0;
    plan_idx = 0;
    while (total < RANDOM_ITEMS) begin
      value = (plan_idx < 16) ? cfg_plan[plan_idx] : 7'($urandom_range(1, 10));
      write_individuals(value);
      sender_gaps = ($urandom_range(0, 2) != 0);
      burst_left  = $urandom_range(1, 24);
      if (plan_idx == 1 || plan_idx == 6) hold_request = 1'b1;
      // large sites cost many beats: keep those phases short
      budget = (current_eff > 16) ? 2 * current_eff : $urandom_range(60, 120);
      phase_items = 0;
      while (phase_items < budget) begin
        sites = (current_eff > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        run_contig(sites);
        phase_items += sites * current_eff;
      end
      stop_sending();
      wait_idle();
      total += phase_items;
      plan_idx++;
    end

    drain = 0;
    while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (IDLE_SETTLE) @(posedge clk);
    sb.count_leftovers();
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
